// ===== design/pfwc_pkg.sv =====
// Package for the PLL frequency word calculator.
// Holds the word sequence type, register codes, reset words and divider constants.
// No dependencies.
package pfwc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_R4_BASE = 2'd0;
  localparam logic [1:0] CFG_R1_BASE = 2'd1;
  localparam logic [1:0] CFG_R0_BASE = 2'd2;

  // Reset values of the base words.
  localparam logic [31:0] R4_BASE_RST = 32'd11862524;
  localparam logic [31:0] R1_BASE_RST = 32'd134250505;
  localparam logic [31:0] R0_BASE_RST = 32'd13107200;

  // Synthesizer register numbers carried with each word.
  localparam logic [2:0] REG_NUM_R4 = 3'd4;
  localparam logic [2:0] REG_NUM_R1 = 3'd1;
  localparam logic [2:0] REG_NUM_R0 = 3'd0;

  // Field masks before shifting.
  localparam logic [2:0]  RFDIV_FIELD = 3'h7;
  localparam logic [11:0] MOD_FIELD   = 12'hFFF;
  localparam logic [11:0] FRAC_FIELD  = 12'hFFF;
  localparam logic [15:0] INT_FIELD   = 16'hFFFF;

  // Fixed fractional modulus.
  localparam logic [11:0] MODULUS = 12'd1000;
  localparam logic [9:0]  MOD_K   = 10'd1000;

  // Highest output divider code.
  localparam logic [2:0] DIV_MAX = 3'd6;

  // Division of vco/16 by 625: floor(2^32 / 625), error below one.
  localparam logic [22:0] RECIP_625 = 23'd6871947;
  localparam logic [9:0]  K_625     = 10'd625;
  // Division of q/8 by 125: floor(2^24 / 125), error below one.
  localparam logic [17:0] RECIP_125 = 18'd134217;

  // Lowest input frequency for each divider code (2.2 GHz / 2^d).
  localparam logic [32:0] FMIN_D0 = 33'd2200000000;
  localparam logic [32:0] FMIN_D1 = 33'd1100000000;
  localparam logic [32:0] FMIN_D2 = 33'd550000000;
  localparam logic [32:0] FMIN_D3 = 33'd275000000;
  localparam logic [32:0] FMIN_D4 = 33'd137500000;
  localparam logic [32:0] FMIN_D5 = 33'd68750000;
  localparam logic [32:0] FMIN_D6 = 33'd34375000;

  // Output word sequence, one-hot.
  typedef enum logic [2:0] {
    WORD_R4 = 3'b001,
    WORD_R1 = 3'b010,
    WORD_R0 = 3'b100
  } word_e;

  // Smallest divider code that lifts the VCO to 2.2 GHz, saturating at six.
  function automatic logic [2:0] div_code(input logic [32:0] freq);
    logic [2:0] code;
    priority if (freq >= FMIN_D0) code = 3'd0;
    else if (freq >= FMIN_D1) code = 3'd1;
    else if (freq >= FMIN_D2) code = 3'd2;
    else if (freq >= FMIN_D3) code = 3'd3;
    else if (freq >= FMIN_D4) code = 3'd4;
    else if (freq >= FMIN_D5) code = 3'd5;
    else code = DIV_MAX;
    return code;
  endfunction

endpackage

// ===== design/pll_frequency_word_calculator.sv =====
// PLL frequency word calculator: divider, INT and FRAC pipeline and word sender.
// Depends on pfwc_pkg for constants, the word sequence type and the divider search.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, freq_hz_i         | in
//   output  | out_valid_o, out_stall_i, reg_word_o,     | out
//           | reg_number_o, last_word_o, range_error_o  |
//   config  | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//           | cfg_data_i                                |
//
// Five register stages compute the divider, vco/10 kHz and its split into INT and FRAC.
// The output stage sends three words per item, holding each while out_stall_i is high,
// and so sets the sustained rate; the stages ahead of it keep taking items until full.
// Reset clears all valid bits and loads the reset base words; a stage waits only
// while the stage after it is full and cannot move on.
module pll_frequency_word_calculator
  import pfwc_pkg::*;
#(
  parameter int unsigned RFDIV_SHIFT = 20,
  parameter int unsigned MOD_SHIFT   = 3,
  parameter int unsigned FRAC_SHIFT  = 3,
  parameter int unsigned INT_SHIFT   = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [32:0] freq_hz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] reg_word_o,
  output logic [2:0]  reg_number_o,
  output logic        last_word_o,
  output logic        range_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Field masks in place within the 32-bit words.
  localparam logic [31:0] RFDIV_MASK = 32'(64'(RFDIV_FIELD) << RFDIV_SHIFT);
  localparam logic [31:0] MOD_MASK   = 32'(64'(MOD_FIELD) << MOD_SHIFT);
  localparam logic [31:0] FRAC_MASK  = 32'(64'(FRAC_FIELD) << FRAC_SHIFT);
  localparam logic [31:0] INT_MASK   = 32'(64'(INT_FIELD) << INT_SHIFT);
  localparam logic [31:0] MOD_WORD   = 32'(64'(MODULUS) << MOD_SHIFT) & MOD_MASK;

  // Configuration registers.
  logic [31:0] r4_base_q, r1_base_q, r0_base_q;

  // Pipeline valid bits and stage enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic take1, take2, take3, take4, take5, out_take;

  // Stage payloads.
  logic [28:0] x1_q, x2_q;
  logic [2:0]  div1_q, div2_q, div3_q, div4_q, div5_q, div_q;
  logic        err1_q, err2_q, err3_q, err4_q, err5_q, err_q;
  logic [51:0] p2_q;
  logic [19:0] q3_q, q4_q;
  logic [34:0] p4_q;
  logic [9:0]  iv5_q, fv5_q, iv_q, fv_q;
  word_e       word_q, word_d;

  // Stage logic.
  logic [2:0]  div1_d;
  logic [32:0] vco1_d;
  logic [19:0] qest3;
  logic [29:0] prod3, rem3;
  logic [19:0] q3_d;
  logic [9:0]  ivest5;
  logic [19:0] prod5, rem5;
  logic        fix5;
  logic        last_sent;

  // Handshake: a stage takes new data when empty or when it passes its own on.
  assign last_sent  = ov_q && !out_stall_i && (word_q == WORD_R0);
  assign out_take   = !ov_q || last_sent;
  assign take5      = !v5_q || out_take;
  assign take4      = !v4_q || take5;
  assign take3      = !v3_q || take4;
  assign take2      = !v2_q || take3;
  assign take1      = !v1_q || take2;
  assign in_stall_o = !take1;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r4_base_q <= R4_BASE_RST;
      r1_base_q <= R1_BASE_RST;
      r0_base_q <= R0_BASE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_R4_BASE: r4_base_q <= cfg_data_i;
        CFG_R1_BASE: r1_base_q <= cfg_data_i;
        CFG_R0_BASE: r0_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: divider code and VCO frequency; the VCO always fits 33 bits.
  always_comb begin
    div1_d = div_code(freq_hz_i);
    vco1_d = freq_hz_i << div1_d;
  end

  // Stage 3: quotient by 625 from the reciprocal estimate, corrected by one step.
  always_comb begin
    qest3 = p2_q[51:32];
    prod3 = 30'(qest3) * 30'(K_625);
    rem3  = 30'(x2_q) - prod3;
    q3_d  = qest3 + 20'(rem3 >= 30'(K_625));
  end

  // Stage 5: split vco/10 kHz into INT and FRAC by dividing by 1000.
  always_comb begin
    ivest5 = p4_q[33:24];
    prod5  = 20'(ivest5) * 20'(MOD_K);
    rem5   = q4_q - prod5;
    fix5   = rem5 >= 20'(MOD_K);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (take1) v1_q <= in_valid_i;
      if (take2) v2_q <= v1_q;
      if (take3) v3_q <= v2_q;
      if (take4) v4_q <= v3_q;
      if (take5) v5_q <= v4_q;
      if (out_take) ov_q <= v5_q;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (take1) begin
      x1_q   <= vco1_d[32:4];
      div1_q <= div1_d;
      err1_q <= freq_hz_i < FMIN_D6;
    end
    if (take2) begin
      p2_q   <= 52'(x1_q) * 52'(RECIP_625);
      x2_q   <= x1_q;
      div2_q <= div1_q;
      err2_q <= err1_q;
    end
    if (take3) begin
      q3_q   <= q3_d;
      div3_q <= div2_q;
      err3_q <= err2_q;
    end
    if (take4) begin
      p4_q   <= 35'(q3_q[19:3]) * 35'(RECIP_125);
      q4_q   <= q3_q;
      div4_q <= div3_q;
      err4_q <= err3_q;
    end
    if (take5) begin
      iv5_q  <= ivest5 + 10'(fix5);
      fv5_q  <= fix5 ? 10'(rem5 - 20'(MOD_K)) : rem5[9:0];
      div5_q <= div4_q;
      err5_q <= err4_q;
    end
    if (out_take) begin
      iv_q  <= iv5_q;
      fv_q  <= fv5_q;
      div_q <= div5_q;
      err_q <= err5_q;
    end
  end

  // Word sequencer: R4, R1, R0, then the next item.
  always_comb begin
    word_d = word_q;
    if (out_take) begin
      word_d = WORD_R4;
    end else if (!out_stall_i) begin
      unique case (word_q)
        WORD_R4: word_d = WORD_R1;
        WORD_R1: word_d = WORD_R0;
        WORD_R0: word_d = WORD_R4;
        default: word_d = WORD_R4;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= WORD_R4;
    end else begin
      word_q <= word_d;
    end
  end

  // Merge the fields into the base word of the register being sent.
  always_comb begin
    reg_word_o   = r4_base_q;
    reg_number_o = REG_NUM_R4;
    unique case (word_q)
      WORD_R4: begin
        reg_word_o   = (r4_base_q & ~RFDIV_MASK) |
                       (32'(64'(div_q) << RFDIV_SHIFT) & RFDIV_MASK);
        reg_number_o = REG_NUM_R4;
      end
      WORD_R1: begin
        reg_word_o   = (r1_base_q & ~MOD_MASK) | MOD_WORD;
        reg_number_o = REG_NUM_R1;
      end
      WORD_R0: begin
        reg_word_o   = (r0_base_q & ~FRAC_MASK & ~INT_MASK) |
                       (32'(64'(fv_q) << FRAC_SHIFT) & FRAC_MASK) |
                       (32'(64'(iv_q) << INT_SHIFT) & INT_MASK);
        reg_number_o = REG_NUM_R0;
      end
      default: begin
        reg_word_o   = r4_base_q;
        reg_number_o = REG_NUM_R4;
      end
    endcase
  end

  assign out_valid_o   = ov_q;
  assign last_word_o   = (word_q == WORD_R0);
  assign range_error_o = err_q;

`ifndef SYNTHESIS
  // The sequencer always holds exactly one word position.
  a_word_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(word_q)) else $error("word sequencer lost its one-hot code");

  // The corrected division leaves FRAC below the modulus and INT in range.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (fv_q < MOD_K) && (iv_q < 10'd860))
    else $error("INT or FRAC out of range");

  // A saturated divider is the only case with the error flag.
  a_err_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && err_q |-> div_q == DIV_MAX) else $error("range error without saturated divider");

  // The input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q && v4_q && v5_q && ov_q)
    else $error("input stalled with an empty stage");

  // A new item starts at register 4.
  a_new_item_r4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && v5_q |=> word_q == WORD_R4) else $error("item did not start at register 4");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench for pll_frequency_word_calculator: drives frequency requests and base-word writes,
// predicts the three register words of each request, and checks every word that comes out.
// Depends on pfwc_pkg and the RTL under design/.
module testbench;
  import pfwc_pkg::*;

  // Field positions used for this run; the block is built with the same values.
  localparam int unsigned RFDIV_POS = 20;
  localparam int unsigned MOD_POS   = 3;
  localparam int unsigned FRAC_POS  = 3;
  localparam int unsigned INT_POS   = 15;

  // Index past the last base register; writes to it change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [63:0] VCO_FLOOR_HZ = 64'd2200000000;
  localparam logic [63:0] PFD_HZ       = 64'd10000000;
  localparam logic [63:0] CHANNEL_HZ   = 64'd10000;
  localparam logic [63:0] FRAC_MOD     = 64'd1000;
  localparam logic [63:0] TOP_FREQ_HZ  = 64'd4400000000;

  localparam int RUN_LIMIT = 2000000;

  // One register word as it leaves the block.
  typedef struct packed {
    logic [31:0] reg_word;
    logic [2:0]  reg_number;
    logic        last_word;
    logic        range_error;
  } synth_word_t;

  // Holds the base words and the words still owed by the block.
  class freq_word_board;
    synth_word_t pending_words[$];
    logic [31:0] r4_word;
    logic [31:0] r1_word;
    logic [31:0] r0_word;
    int unsigned mismatches;

    function new();
      r4_word = R4_BASE_RST;
      r1_word = R1_BASE_RST;
      r0_word = R0_BASE_RST;
      mismatches = 0;
    endfunction

    function void set_base(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
        CFG_R4_BASE: r4_word = data;
        CFG_R1_BASE: r1_word = data;
        CFG_R0_BASE: r0_word = data;
        default: ;
      endcase
    endfunction

    // Prints one line per mismatch and counts it.
    task report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Works out the three words for an accepted frequency request.
    function void note_request(input logic [32:0] freq);
      logic [63:0] vco;
      logic [63:0] int_part;
      logic [63:0] frac_part;
      logic [2:0]  code;
      logic        too_low;
      logic [31:0] w4;
      logic [31:0] w1;
      logic [31:0] w0;
      code = 3'd0;
      vco = 64'(freq);
      while (vco < VCO_FLOOR_HZ && code < DIV_MAX) begin
        code++;
        vco = 64'(freq) << code;
      end
      too_low = (vco < VCO_FLOOR_HZ);
      int_part = vco / PFD_HZ;
      frac_part = vco / CHANNEL_HZ - int_part * FRAC_MOD;

      w4 = (r4_word & ~(32'(RFDIV_FIELD) << RFDIV_POS)) | (32'(code) << RFDIV_POS);
      w1 = (r1_word & ~(32'(MOD_FIELD) << MOD_POS)) | (32'(MODULUS) << MOD_POS);
      // FRAC and INT are cleared and then ORed in; with these positions the fields do not overlap.
      w0 = r0_word & ~(32'(FRAC_FIELD) << FRAC_POS);
      w0 = w0 & ~(32'(INT_FIELD) << INT_POS);
      w0 = w0 | (32'(frac_part[11:0]) << FRAC_POS);
      w0 = w0 | (32'(int_part[15:0]) << INT_POS);

      pending_words.push_back('{w4, REG_NUM_R4, 1'b0, too_low});
      pending_words.push_back('{w1, REG_NUM_R1, 1'b0, too_low});
      pending_words.push_back('{w0, REG_NUM_R0, 1'b1, too_low});
    endfunction

    // Compares an accepted word with the oldest one owed.
    task check_word(input synth_word_t got);
      synth_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("word %h reg %0d with nothing owed", got.reg_word, got.reg_number));
        return;
      end
      want = pending_words.pop_front();
      if (got.reg_word !== want.reg_word)
        report($sformatf("reg_word %h, wanted %h", got.reg_word, want.reg_word));
      if (got.reg_number !== want.reg_number)
        report($sformatf("reg_number %0d, wanted %0d", got.reg_number, want.reg_number));
      if (got.last_word !== want.last_word)
        report($sformatf("last_word %b, wanted %b", got.last_word, want.last_word));
      if (got.range_error !== want.range_error)
        report($sformatf("range_error %b, wanted %b", got.range_error, want.range_error));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [32:0] freq_hz;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] reg_word;
  logic [2:0]  reg_number;
  logic        last_word;
  logic        range_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  freq_word_board board;
  bit          idle_on;
  bit          hold_on;
  int unsigned items_sent;

  pll_frequency_word_calculator #(
    .RFDIV_SHIFT(RFDIV_POS),
    .MOD_SHIFT  (MOD_POS),
    .FRAC_SHIFT (FRAC_POS),
    .INT_SHIFT  (INT_POS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .freq_hz_i    (freq_hz),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .reg_word_o   (reg_word),
    .reg_number_o (reg_number),
    .last_word_o  (last_word),
    .range_error_o(range_error),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Clock with a period of 10.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The receiver stalls at random, and throughout a long hold-off.
  always @(negedge clk_i) begin
    out_stall <= hold_on || (idle_on && $urandom_range(99, 0) < 8);
  end

  // Every word accepted at a rising edge goes to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      board.check_word('{reg_word, reg_number, last_word, range_error});
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    hold_on = 1'b0;
    wait (items_sent >= 60);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (250) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Ends a run that hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one request and waits until the block takes it.
  task automatic send_freq(input logic [32:0] f);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99, 0) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    freq_hz <= f;
    do @(posedge clk_i); while (in_stall);
    board.note_request(f);
    items_sent++;
  endtask

  // Writes one base register through the configuration channel.
  task automatic write_base(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    board.set_base(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Lowers valid and waits until every owed word has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] w4, input logic [31:0] w1,
                           input logic [31:0] w0);
    write_base(CFG_R4_BASE, w4);
    write_base(CFG_R1_BASE, w1);
    write_base(CFG_R0_BASE, w0);
  endtask

  // Random frequency: mostly in range, with low values, divider edges and full 33-bit values.
  function automatic logic [32:0] pick_freq();
    logic [32:0] edges [7];
    logic [63:0] wide;
    int          sel;
    edges = '{FMIN_D0, FMIN_D1, FMIN_D2, FMIN_D3, FMIN_D4, FMIN_D5, FMIN_D6};
    sel = $urandom_range(99, 0);
    if (sel < 10)
      return 33'($urandom_range(34374999, 0));
    if (sel < 30)
      return edges[$urandom_range(6, 0)] + 33'($urandom_range(6, 0)) - 33'd3;
    if (sel < 35)
      return {1'($urandom_range(1, 0)), 32'($urandom())};
    wide = {32'($urandom()), 32'($urandom())};
    return 33'(wide % (TOP_FREQ_HZ + 64'd1));
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_freq(pick_freq());
  endtask

  // Directed frequencies: zero, divider boundaries and the ends of the input range.
  logic [32:0] corner_freqs [] = '{
    33'd0, 33'd1, 33'd34374999, 33'd34375000, 33'd68749999, 33'd68750000,
    33'd137499999, 33'd137500000, 33'd274999999, 33'd275000000, 33'd549999999,
    33'd550000000, 33'd1099999999, 33'd1100000000, 33'd2199999999, 33'd2200000000,
    33'd2200010000, 33'd4294967295, 33'd4294967296, 33'd4400000000, 33'd8589934591,
    33'd123456789
  };

  // Reset, then phases of requests under different base words.
  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    freq_hz = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_R4_BASE;
    cfg_data = '0;
    idle_on = 1'b1;
    items_sent = 0;
    board = new();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset base words with the directed requests, then random ones.
    foreach (corner_freqs[i]) send_freq(corner_freqs[i]);
    send_random(100);
    drain();

    // All-zero base words; the unused index must change nothing.
    write_all(32'h0, 32'h0, 32'h0);
    write_base(CFG_UNUSED, $urandom());
    send_random(100);
    drain();

    // All-ones base words, with no idling on either side.
    idle_on = 1'b0;
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(100);
    drain();
    idle_on = 1'b1;

    // Random base words, twice.
    write_all($urandom(), $urandom(), $urandom());
    send_random(100);
    drain();
    write_all($urandom(), $urandom(), $urandom());
    write_base(CFG_UNUSED, 32'hFFFF_FFFF);
    send_random(100);
    drain();

    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
